FILE: hw/rtl/complex_arithmetic_unit_macros.svh
// assertion macros for the complex arithmetic unit
// used by complex_arithmetic_unit.sv, no other dependencies
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cau_pkg.sv
// shared constants, codes and pipeline payload types of the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  // quotient bits resolved per divider stage
  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_STG   = DATA_W / DIV_BITS;

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // finished result fields
  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              cmp;
    status_e           status;
  } res_t;

  // item state inside the divider pipeline
  typedef struct packed {
    logic              is_div;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [PROD_W-1:0] den;
    logic [PROD_W-1:0] rem_re;
    logic [PROD_W-1:0] rem_im;
    logic [DATA_W-1:0] num_re;
    logic [DATA_W-1:0] num_im;
    logic [DATA_W-1:0] quo_re;
    logic [DATA_W-1:0] quo_im;
    res_t              res;
  } div_t;

endpackage

FILE: hw/rtl/complex_arithmetic_unit.sv
// complex arithmetic unit: add, subtract, multiply, divide and compare in Q16.16
// depends on cau_pkg, cau_divider and complex_arithmetic_unit_macros.svh
//
// usage
//   input item: s_axis_tuser carries the op code, s_axis_tdata the four operand
//   parts; one item is taken at each edge where s_axis_tvalid and s_axis_tready
//   are high. result item: m_axis_tdata holds the real and imaginary result,
//   m_axis_tuser the compare flag and the status.
//   every op passes 22 register stages: five front stages (operand register,
//   products, sums, magnitudes, divider setup), sixteen divider stages that each
//   settle two quotient bits, and the output register. throughput is one item
//   per cycle while the receiver keeps m_axis_tready high.
//   every stage holds its item while the next one is full and stalled, and a
//   stage that is empty still takes a new item, so bubbles close up when the
//   receiver holds m_axis_tready low; s_axis_tready drops only once all stages
//   are full.
//   reset clears every valid bit; no item is in flight afterwards and the block
//   takes input in the first cycle after reset is released.
module complex_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_real [31:0], a_imag [63:32], b_real [95:64], b_imag [127:96]
  input  logic [127:0] s_axis_tdata,
  // op [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_real [31:0], res_imag [63:32]
  output logic [63:0]  m_axis_tdata,
  // cmp_true [0], status [2:1]
  output logic [2:0]   m_axis_tuser
);

  localparam int unsigned DW = cau_pkg::DATA_W;
  localparam int unsigned PW = cau_pkg::PROD_W;
  localparam int unsigned SW = cau_pkg::SUM_W;
  localparam int unsigned FB = cau_pkg::FRAC_BITS;

  localparam logic [PW-1:0] MAG_POS_LIM = {{(PW-DW){1'b0}}, cau_pkg::POS_MAX};
  localparam logic [PW-1:0] MAG_NEG_LIM = {{(PW-DW){1'b0}}, cau_pkg::NEG_MIN};

  // saturate sign and magnitude to a signed word, flag in the top bit
  function automatic logic [DW:0] sat_mag(input logic neg, input logic [PW-1:0] mag);
    logic [DW-1:0] low;
    low = mag[DW-1:0];
    if (!neg) begin
      return (mag > MAG_POS_LIM) ? {1'b1, cau_pkg::POS_MAX} : {1'b0, low};
    end
    return (mag > MAG_NEG_LIM) ? {1'b1, cau_pkg::NEG_MIN} : {1'b0, (~low) + 1'b1};
  endfunction

  // saturate a one-bit-wider sum
  function automatic logic [DW:0] sat_sum(input logic [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? {1'b1, cau_pkg::NEG_MIN} : {1'b1, cau_pkg::POS_MAX};
    end
    return {1'b0, s[DW-1:0]};
  endfunction

  // advance chain
  logic adv1, adv2, adv3, adv4, adv5, out_adv;
  logic div_in_ready, div_out_valid;
  cau_pkg::div_t div_out;

  // stage 1: operand register
  logic                 s1_vld_q;
  logic [cau_pkg::OP_W-1:0] s1_op_q;
  logic signed [DW-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  // stage 2: products and finished add, sub and compare results
  logic                 s2_vld_q;
  logic [cau_pkg::OP_W-1:0] s2_op_q;
  logic signed [PW-1:0] s2_rr_q, s2_ii_q, s2_ir_q, s2_ri_q, s2_bbr_q, s2_bbi_q;
  logic signed [PW-1:0] s2_rr_d, s2_ii_d, s2_ir_d, s2_ri_d, s2_bbr_d, s2_bbi_d;
  cau_pkg::res_t        s2_res_q, s2_res_d;

  // stage 3: sums and squared magnitude
  logic                 s3_vld_q;
  logic [cau_pkg::OP_W-1:0] s3_op_q;
  logic [SW-1:0]        s3_re_q, s3_im_q, s3_re_d, s3_im_d;
  logic [PW-1:0]        s3_den_q, s3_den_d;
  cau_pkg::res_t        s3_res_q;

  // stage 4: sign and magnitude
  logic                 s4_vld_q;
  logic [cau_pkg::OP_W-1:0] s4_op_q;
  logic                 s4_neg_re_q, s4_neg_im_q;
  logic [PW-1:0]        s4_mag_re_q, s4_mag_im_q, s4_mag_re_d, s4_mag_im_d;
  logic [PW-1:0]        s4_den_q;
  cau_pkg::res_t        s4_res_q;

  // stage 5: divider setup and multiply saturation
  logic                 s5_vld_q;
  cau_pkg::div_t        s5_q, s5_d;

  // output register
  logic                 out_vld_q;
  cau_pkg::res_t        out_q, out_d;

  assign out_adv       = ~out_vld_q | m_axis_tready;
  assign adv5          = ~s5_vld_q | div_in_ready;
  assign adv4          = ~s4_vld_q | adv5;
  assign adv3          = ~s3_vld_q | adv4;
  assign adv2          = ~s2_vld_q | adv3;
  assign adv1          = ~s1_vld_q | adv2;
  assign s_axis_tready = adv1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv1) s1_vld_q <= s_axis_tvalid;
      if (adv2) s2_vld_q <= s1_vld_q;
      if (adv3) s3_vld_q <= s2_vld_q;
      if (adv4) s4_vld_q <= s3_vld_q;
      if (adv5) s5_vld_q <= s4_vld_q;
      if (out_adv) out_vld_q <= div_out_valid;
    end
  end

  // stage 2 logic: products, add, sub and compare
  always_comb begin
    logic [DW:0] sr;
    logic [DW:0] si;
    logic [DW:0] fr;
    logic [DW:0] fi;
    logic        eq;
    s2_rr_d  = s1_ar_q * s1_br_q;
    s2_ii_d  = s1_ai_q * s1_bi_q;
    s2_ir_d  = s1_ai_q * s1_br_q;
    s2_ri_d  = s1_ar_q * s1_bi_q;
    s2_bbr_d = s1_br_q * s1_br_q;
    s2_bbi_d = s1_bi_q * s1_bi_q;
    if (s1_op_q == cau_pkg::OP_SUB) begin
      sr = {s1_ar_q[DW-1], s1_ar_q} - {s1_br_q[DW-1], s1_br_q};
      si = {s1_ai_q[DW-1], s1_ai_q} - {s1_bi_q[DW-1], s1_bi_q};
    end else begin
      sr = {s1_ar_q[DW-1], s1_ar_q} + {s1_br_q[DW-1], s1_br_q};
      si = {s1_ai_q[DW-1], s1_ai_q} + {s1_bi_q[DW-1], s1_bi_q};
    end
    fr = sat_sum(sr);
    fi = sat_sum(si);
    eq = (s1_ar_q == s1_br_q) && (s1_ai_q == s1_bi_q);
    s2_res_d = '{re: '0, im: '0, cmp: 1'b0, status: cau_pkg::ST_OK};
    case (cau_pkg::op_e'(s1_op_q))
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s2_res_d.re     = fr[DW-1:0];
        s2_res_d.im     = fi[DW-1:0];
        s2_res_d.status = (fr[DW] | fi[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_EQ: begin
        s2_res_d.cmp = eq;
      end
      cau_pkg::OP_NE: begin
        s2_res_d.cmp = ~eq;
      end
      default: begin
        s2_res_d.cmp = 1'b0;
      end
    endcase
  end

  // stage 3 logic: sums of products
  always_comb begin
    logic [SW-1:0] rr;
    logic [SW-1:0] ii;
    logic [SW-1:0] ir;
    logic [SW-1:0] ri;
    rr = {s2_rr_q[PW-1], s2_rr_q};
    ii = {s2_ii_q[PW-1], s2_ii_q};
    ir = {s2_ir_q[PW-1], s2_ir_q};
    ri = {s2_ri_q[PW-1], s2_ri_q};
    if (s2_op_q == cau_pkg::OP_MUL) begin
      s3_re_d = rr - ii;
      s3_im_d = ir + ri;
    end else begin
      s3_re_d = rr + ii;
      s3_im_d = ir - ri;
    end
    s3_den_d = s2_bbr_q + s2_bbi_q;
  end

  // stage 4 logic: magnitudes
  always_comb begin
    logic [SW-1:0] nr;
    logic [SW-1:0] ni;
    nr = s3_re_q[SW-1] ? (~s3_re_q) + 1'b1 : s3_re_q;
    ni = s3_im_q[SW-1] ? (~s3_im_q) + 1'b1 : s3_im_q;
    s4_mag_re_d = nr[PW-1:0];
    s4_mag_im_d = ni[PW-1:0];
  end

  // stage 5 logic: multiply result or divider start values
  always_comb begin
    logic [PW-1:0] hr;
    logic [PW-1:0] hi;
    logic [DW:0]   mr;
    logic [DW:0]   mi;
    hr = s4_mag_re_q >> FB;
    hi = s4_mag_im_q >> FB;
    mr = sat_mag(s4_neg_re_q, hr);
    mi = sat_mag(s4_neg_im_q, hi);
    s5_d        = '0;
    s5_d.res    = s4_res_q;
    s5_d.neg_re = s4_neg_re_q;
    s5_d.neg_im = s4_neg_im_q;
    s5_d.den    = s4_den_q;
    s5_d.rem_re = hr;
    s5_d.rem_im = hi;
    s5_d.num_re = {s4_mag_re_q[DW-FB-1:0], {FB{1'b0}}};
    s5_d.num_im = {s4_mag_im_q[DW-FB-1:0], {FB{1'b0}}};
    s5_d.ovf_re = (hr >= s4_den_q);
    s5_d.ovf_im = (hi >= s4_den_q);
    case (cau_pkg::op_e'(s4_op_q))
      cau_pkg::OP_MUL: begin
        s5_d.res.re     = mr[DW-1:0];
        s5_d.res.im     = mi[DW-1:0];
        s5_d.res.status = (mr[DW] | mi[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        if (s4_den_q == '0) begin
          s5_d.res.status = cau_pkg::ST_DIV0;
        end else begin
          s5_d.is_div = 1'b1;
        end
      end
      default: begin
        s5_d.is_div = 1'b0;
      end
    endcase
  end

  // output logic: quotient saturation
  always_comb begin
    logic [DW:0] qr;
    logic [DW:0] qi;
    qr = sat_mag(div_out.neg_re,
                 div_out.ovf_re ? {PW{1'b1}} : {{(PW-DW){1'b0}}, div_out.quo_re});
    qi = sat_mag(div_out.neg_im,
                 div_out.ovf_im ? {PW{1'b1}} : {{(PW-DW){1'b0}}, div_out.quo_im});
    out_d = div_out.res;
    if (div_out.is_div) begin
      out_d.re     = qr[DW-1:0];
      out_d.im     = qi[DW-1:0];
      out_d.cmp    = 1'b0;
      out_d.status = (qr[DW] | qi[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_op_q <= s_axis_tuser;
      s1_ar_q <= s_axis_tdata[DW-1:0];
      s1_ai_q <= s_axis_tdata[2*DW-1:DW];
      s1_br_q <= s_axis_tdata[3*DW-1:2*DW];
      s1_bi_q <= s_axis_tdata[4*DW-1:3*DW];
    end
    if (adv2) begin
      s2_op_q  <= s1_op_q;
      s2_rr_q  <= s2_rr_d;
      s2_ii_q  <= s2_ii_d;
      s2_ir_q  <= s2_ir_d;
      s2_ri_q  <= s2_ri_d;
      s2_bbr_q <= s2_bbr_d;
      s2_bbi_q <= s2_bbi_d;
      s2_res_q <= s2_res_d;
    end
    if (adv3) begin
      s3_op_q  <= s2_op_q;
      s3_re_q  <= s3_re_d;
      s3_im_q  <= s3_im_d;
      s3_den_q <= s3_den_d;
      s3_res_q <= s2_res_q;
    end
    if (adv4) begin
      s4_op_q     <= s3_op_q;
      s4_neg_re_q <= s3_re_q[SW-1];
      s4_neg_im_q <= s3_im_q[SW-1];
      s4_mag_re_q <= s4_mag_re_d;
      s4_mag_im_q <= s4_mag_im_d;
      s4_den_q    <= s3_den_q;
      s4_res_q    <= s3_res_q;
    end
    if (adv5) begin
      s5_q <= s5_d;
    end
    if (out_adv) begin
      out_q <= out_d;
    end
  end

  // quotient pipeline
  cau_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s5_vld_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (s5_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (out_adv),
    .out_data_o  (div_out)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.im, out_q.re};
  assign m_axis_tuser  = {out_q.status, out_q.cmp};

  // checks
  `include "complex_arithmetic_unit_macros.svh"

  `CAU_ASSERT_IMP(a_div0_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:1] == cau_pkg::ST_DIV0), (m_axis_tdata == '0) && !m_axis_tuser[0], "divide by zero result not zero")
  `CAU_ASSERT_IMP(a_cmp_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && (m_axis_tuser[2:1] == cau_pkg::ST_OK), "compare result carries data")
  `CAU_ASSERT_IMP(a_sat_limit, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[2:1] == cau_pkg::ST_SAT), (m_axis_tdata[31:0] == cau_pkg::POS_MAX) || (m_axis_tdata[31:0] == cau_pkg::NEG_MIN) || (m_axis_tdata[63:32] == cau_pkg::POS_MAX) || (m_axis_tdata[63:32] == cau_pkg::NEG_MIN), "saturated result not at a limit")
  `CAU_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_vld_q && !adv2, s1_vld_q, "stalled operand stage lost its item")

endmodule

FILE: hw/rtl/cau_divider.sv
// pipelined restoring divider, two quotient bits per stage for both lanes
// depends on cau_pkg
module cau_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cau_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cau_pkg::div_t out_data_o
);

  cau_pkg::div_t                 stg_q  [cau_pkg::DIV_STG];
  cau_pkg::div_t                 src    [cau_pkg::DIV_STG];
  cau_pkg::div_t                 step_d [cau_pkg::DIV_STG];
  logic [cau_pkg::DIV_STG-1:0]   vld_q;
  logic [cau_pkg::DIV_STG-1:0]   src_vld;
  logic [cau_pkg::DIV_STG:0]     adv;

  // shift-subtract steps on one item
  function automatic cau_pkg::div_t div_step(input cau_pkg::div_t d);
    logic [cau_pkg::PROD_W:0] t_re;
    logic [cau_pkg::PROD_W:0] t_im;
    logic [cau_pkg::PROD_W:0] df_re;
    logic [cau_pkg::PROD_W:0] df_im;
    logic                     ge_re;
    logic                     ge_im;
    cau_pkg::div_t            n;
    n = d;
    for (int i = 0; i < cau_pkg::DIV_BITS; i++) begin
      t_re  = {n.rem_re, n.num_re[cau_pkg::DATA_W-1]};
      t_im  = {n.rem_im, n.num_im[cau_pkg::DATA_W-1]};
      df_re = t_re - {1'b0, n.den};
      df_im = t_im - {1'b0, n.den};
      ge_re = (t_re >= {1'b0, n.den});
      ge_im = (t_im >= {1'b0, n.den});
      n.rem_re = ge_re ? df_re[cau_pkg::PROD_W-1:0] : t_re[cau_pkg::PROD_W-1:0];
      n.rem_im = ge_im ? df_im[cau_pkg::PROD_W-1:0] : t_im[cau_pkg::PROD_W-1:0];
      n.quo_re = {n.quo_re[cau_pkg::DATA_W-2:0], ge_re};
      n.quo_im = {n.quo_im[cau_pkg::DATA_W-2:0], ge_im};
      n.num_re = {n.num_re[cau_pkg::DATA_W-2:0], 1'b0};
      n.num_im = {n.num_im[cau_pkg::DATA_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // stage sources and the advance chain, last stage first
  always_comb begin
    adv[cau_pkg::DIV_STG] = out_ready_i;
    for (int k = cau_pkg::DIV_STG - 1; k >= 0; k--) begin
      adv[k] = ~vld_q[k] | adv[k+1];
    end
    src[0]     = in_data_i;
    src_vld[0] = in_valid_i;
    for (int k = 1; k < cau_pkg::DIV_STG; k++) begin
      src[k]     = stg_q[k-1];
      src_vld[k] = vld_q[k-1];
    end
    for (int k = 0; k < cau_pkg::DIV_STG; k++) begin
      step_d[k] = div_step(src[k]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < cau_pkg::DIV_STG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= src_vld[k];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < cau_pkg::DIV_STG; k++) begin
      if (adv[k]) begin
        stg_q[k] <= step_d[k];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[cau_pkg::DIV_STG-1];
  assign out_data_o  = stg_q[cau_pkg::DIV_STG-1];

endmodule

FILE: test/tb_top.sv
// testbench for the complex arithmetic unit: directed and random items checked
// against a predictor of sums, products, quotients and compares; needs cau_pkg
module tb_top;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic [1:0]  status;
  } cplx_res_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  cplx_res_t expected_q[$];
  int unsigned error_cnt;
  bit quiet;
  int unsigned stall_cnt;

  complex_arithmetic_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // clamp to signed 32 bits and flag saturation
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // expected result of one operation
  function automatic cplx_res_t complex_result(input logic [2:0] op, input logic [127:0] d);
    logic signed [127:0] ar, ai, br, bi, den, xr, xi;
    cplx_res_t r;
    bit sat;
    ar = $signed(d[31:0]);
    ai = $signed(d[63:32]);
    br = $signed(d[95:64]);
    bi = $signed(d[127:96]);
    r = '0;
    sat = 1'b0;
    case (op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        xr = (op == cau_pkg::OP_ADD) ? ar + br : ar - br;
        xi = (op == cau_pkg::OP_ADD) ? ai + bi : ai - bi;
        r.re = clamp32(xr, sat);
        r.im = clamp32(xi, sat);
        r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_MUL: begin
        // signed division truncates toward zero
        xr = (ar * br - ai * bi) / 128'sd65536;
        xi = (ai * br + ar * bi) / 128'sd65536;
        r.re = clamp32(xr, sat);
        r.im = clamp32(xi, sat);
        r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = cau_pkg::ST_DIV0;
        end else begin
          xr = ((ar * br + ai * bi) * 128'sd65536) / den;
          xi = ((ai * br - ar * bi) * 128'sd65536) / den;
          r.re = clamp32(xr, sat);
          r.im = clamp32(xi, sat);
          r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_EQ: r.cmp = (d[63:0] == d[127:64]);
      cau_pkg::OP_NE: r.cmp = (d[63:0] != d[127:64]);
      default:        r = '0;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    error_cnt++;
  endtask

  // predict on accepted input items, check accepted result items
  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", m_axis_tdata[31:0], 32'h0);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.re) report("res_real", m_axis_tdata[31:0], e.re);
        if (m_axis_tdata[63:32] !== e.im) report("res_imag", m_axis_tdata[63:32], e.im);
        if (m_axis_tuser[0] !== e.cmp)
          report("cmp_true", 32'(m_axis_tuser[0]), 32'(e.cmp));
        if (m_axis_tuser[2:1] !== e.status)
          report("status", 32'(m_axis_tuser[2:1]), 32'(e.status));
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_q.push_back(complex_result(s_axis_tuser, s_axis_tdata));
  end

  // receiver stalls in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= 0;
    end else if (!quiet && stall_cnt > 0) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= stall_cnt - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_cnt     <= (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    end
  end

  // send one item, sometimes with a random gap before it
  task automatic send_item(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bi, br, ai, ar};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
      1:       return $urandom_range(0, 131072) - 65536;
      2:       return $urandom_range(0, 2) - 1;
      3:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // every op on the field extremes
  task automatic test_extremes();
    logic [31:0] vals[4];
    vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
    for (int op = cau_pkg::OP_ADD; op <= cau_pkg::OP_NE; op++) begin
      send_item(3'(op), vals[0], vals[1], vals[0], vals[0]);
      send_item(3'(op), vals[1], vals[0], vals[1], vals[1]);
      send_item(3'(op), vals[3], vals[2], vals[3], vals[3]);
    end
  endtask

  // divide by zero, unit values, a multiply, both compares of equal operands
  task automatic test_special();
    send_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_item(cau_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1);
    send_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'hfffc_0000, 32'h0001_0000, 32'h0002_0000);
    send_item(cau_pkg::OP_MUL, 32'h0001_8000, 32'hffff_8000, 32'h0002_0000, 32'h0000_8000);
    send_item(cau_pkg::OP_EQ,  32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0);
    send_item(cau_pkg::OP_NE,  32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0);
  endtask

  task automatic test_random(input int n);
    logic [31:0] ar, ai, br, bi;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = 3'($urandom_range(cau_pkg::OP_ADD, cau_pkg::OP_NE));
      ar = rand_part();
      ai = rand_part();
      br = rand_part();
      bi = rand_part();
      // half of the compares are met with equal operands or near misses
      if ((op == cau_pkg::OP_EQ || op == cau_pkg::OP_NE) && $urandom_range(0, 1) == 1) begin
        br = ar;
        bi = ($urandom_range(0, 2) == 0) ? ai ^ (32'h1 << $urandom_range(0, 31)) : ai;
      end
      if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
        br = 32'h0;
        bi = 32'h0;
      end
      send_item(op, ar, ai, br, bi);
    end
  endtask

  // timeout
  initial begin
    #3000000;
    $display("FAIL complex_arithmetic_unit");
    $finish;
  end

  initial begin
    error_cnt     = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special();
    test_random(1100);
    quiet = 1'b1;
    test_random(250);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("PASS complex_arithmetic_unit");
    end else begin
      $display("FAIL complex_arithmetic_unit");
    end
    $finish;
  end
endmodule
